// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPOOL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SPOOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/spool_pkg.sv =====
package spool_pkg;

   localparam int UID_W     = 6;
   localparam int MAX_USERS = 2 ** UID_W;
   localparam int QCNT_W    = $clog2(MAX_USERS + 1);
   localparam int CAP_W     = 5;
   localparam int SLOT_OUT_W = 5;

   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_LEAVE = 2'd1;

   typedef enum logic [2:0] {
      OC_GRANTED  = 3'd0,
      OC_QUEUED   = 3'd1,
      OC_REJECTED = 3'd2,
      OC_LEFT     = 3'd3,
      OC_IGNORED  = 3'd4,
      OC_STATUS   = 3'd5
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WAIT = 2'd1,
      ST_HOLD = 2'd2
   } ust_type;

   typedef enum logic [1:0] {
      Q_NONE,
      Q_PUSH,
      Q_DROP,
      Q_POP
   } qop_type;

   typedef struct packed {
      qop_type          op;
      logic [UID_W-1:0] id;
   } qcmd_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [UID_W-1:0] user_id;
   } req_type;

   typedef struct packed {
      logic [2:0]            outcome;
      logic [SLOT_OUT_W-1:0] slot;
      logic [1:0]            user_state;
      logic                  handoff_valid;
      logic [UID_W-1:0]      handoff_user;
      logic [SLOT_OUT_W-1:0] handoff_slot;
      logic [CAP_W-1:0]      occupied;
      logic [QCNT_W-1:0]     waiting;
   } rsp_type;

endpackage

// ===== hdl/slot_pool_with_wait_queue.sv =====
// An accepted item is registered with its user status read and executed in S_EXEC; a leave
// that hands a slot on writes the new holder in S_HAND. The input stalls until the result is
// in the output register (held in S_SEND while it is full). The status memory has one write port.
// Reset: synchronous; all users idle at once through per-entry valid bits (no clearing pass),
// no slot busy, empty queue, capacity 16.
module slot_pool_with_wait_queue #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  spool_pkg::req_type          req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output spool_pkg::rsp_type          rsp_payload,
   input  logic                        csr_write_en,
   input  logic [spool_pkg::CAP_W-1:0] csr_write_data
);
   import spool_pkg::*;
`include "assert_macros.svh"

   localparam int SW = $clog2(NUM_SLOTS + 1);
   localparam int CW = (SW > CAP_W) ? SW : CAP_W;

   // Per-user status word: state code plus the slot held.
   typedef struct packed {
      ust_type       state;
      logic [SW-1:0] slot;
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_HAND,
      S_SEND
   } state_type;

   state_type             state_ff, state_in;
   logic [CAP_W-1:0]      capacity_ff;
   logic [NUM_SLOTS-1:0]  busy_ff, busy_in;
   logic [SW-1:0]         holder_ff, holder_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   rsp_type               res_ff, res_in;
   logic [SW-1:0]         hand_slot_ff, hand_slot_in;
   logic [MAX_USERS-1:0]  vld_ff;

   // Item and memory read registers.
   logic [1:0]            op_ff;
   logic [UID_W-1:0]      uid_ff;
   status_type            rd_stat_ff;
   logic                  rd_vld_ff;

   // User status memory.
   status_type            status_mem [MAX_USERS];
   logic                  mem_we;
   logic [UID_W-1:0]      mem_waddr;
   status_type            mem_wdata;

   qcmd_type              qcmd;
   logic [UID_W-1:0]      q_head;
   logic [QCNT_W-1:0]     q_count;

   logic                  req_accept;
   logic                  out_free;
   logic [CW-1:0]         cap_eff;
   logic                  free_found;
   logic [SW-1:0]         free_slot;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   // The output register can take a new item when empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Clamp the capacity to the slot count.
   always_comb begin
      if (CW'(capacity_ff) > CW'(NUM_SLOTS)) begin
         cap_eff = CW'(NUM_SLOTS);
      end else begin
         cap_eff = CW'(capacity_ff);
      end
   end

   // Lowest-numbered free slot; the last hit in a downward scan wins.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SW'(i + 1);
         end
      end
   end

   spool_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .head  (q_head),
      .count (q_count)
   );

   // Next-state and result logic.
   always_comb begin
      status_type        cur;
      status_type        nxt;
      rsp_type           r;
      logic [QCNT_W-1:0] q_next;
      logic              handoff;
      logic              freed;

      state_in     = state_ff;
      busy_in      = busy_ff;
      holder_in    = holder_ff;
      res_in       = res_ff;
      hand_slot_in = hand_slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = uid_ff;
      mem_wdata    = '0;
      qcmd.op      = Q_NONE;
      qcmd.id      = uid_ff;

      // A never-written entry reads as idle.
      cur = rd_vld_ff ? rd_stat_ff : status_type'{state: ST_IDLE, slot: '0};
      nxt     = cur;
      q_next  = q_count;
      handoff = 1'b0;
      freed   = 1'b0;
      r       = '0;
      r.outcome = OC_STATUS;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (op_ff)
               OP_ENTER: begin
                  if (cur.state != ST_IDLE) begin
                     r.outcome = OC_REJECTED;
                  end else if ((CW'(holder_ff) < cap_eff) && free_found) begin
                     // take the lowest free slot
                     nxt = '{state: ST_HOLD, slot: free_slot};
                     for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (SW'(i + 1) == free_slot) begin
                           busy_in[i] = 1'b1;
                        end
                     end
                     holder_in = holder_ff + 1'b1;
                     mem_we    = 1'b1;
                     r.outcome = OC_GRANTED;
                  end else if (q_count < QCNT_W'(MAX_USERS)) begin
                     // pool full: join the tail of the queue
                     nxt       = '{state: ST_WAIT, slot: '0};
                     qcmd.op   = Q_PUSH;
                     q_next    = q_count + 1'b1;
                     mem_we    = 1'b1;
                     r.outcome = OC_QUEUED;
                  end
               end

               OP_LEAVE: begin
                  if (cur.state == ST_IDLE) begin
                     r.outcome = OC_IGNORED;
                  end else if (cur.state == ST_WAIT) begin
                     // drop from the queue, keep the order of the rest
                     qcmd.op   = Q_DROP;
                     q_next    = q_count - 1'b1;
                     nxt       = '{state: ST_IDLE, slot: '0};
                     mem_we    = 1'b1;
                     r.outcome = OC_LEFT;
                  end else begin
                     if (q_count != '0) begin
                        // hand the slot straight to the queue head
                        qcmd.op         = Q_POP;
                        q_next          = q_count - 1'b1;
                        handoff         = 1'b1;
                        hand_slot_in    = cur.slot;
                        r.handoff_valid = 1'b1;
                        r.handoff_user  = q_head;
                        r.handoff_slot  = SLOT_OUT_W'(cur.slot);
                     end else begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                           if (SW'(i + 1) == cur.slot && busy_ff[i]) begin
                              busy_in[i] = 1'b0;
                              freed      = 1'b1;
                           end
                        end
                        if (freed && holder_ff != '0) begin
                           holder_in = holder_ff - 1'b1;
                        end
                     end
                     nxt       = '{state: ST_IDLE, slot: '0};
                     mem_we    = 1'b1;
                     r.outcome = OC_LEFT;
                  end
               end

               default: begin
               end
            endcase

            mem_wdata    = nxt;
            r.slot       = (nxt.state == ST_HOLD) ? SLOT_OUT_W'(nxt.slot) : '0;
            r.user_state = nxt.state;
            r.occupied   = CAP_W'(holder_in);
            r.waiting    = q_next;

            if (handoff) begin
               res_in   = r;
               state_in = S_HAND;
            end else if (out_free) begin
               rsp_in       = r;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               res_in   = r;
               state_in = S_SEND;
            end
         end

         S_HAND: begin
            // second write: the queue head now holds the slot
            mem_we    = 1'b1;
            mem_waddr = res_ff.handoff_user;
            mem_wdata = '{state: ST_HOLD, slot: hand_slot_ff};
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SEND;
            end
         end

         S_SEND: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAP_W'(16);
         busy_ff      <= '0;
         holder_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         holder_ff    <= holder_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      res_ff       <= res_in;
      hand_slot_ff <= hand_slot_in;
      if (req_accept) begin
         op_ff     <= req_payload.opcode;
         uid_ff    <= req_payload.user_id;
         rd_vld_ff <= vld_ff[req_payload.user_id];
      end
   end

   // User status memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         status_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_stat_ff <= status_mem[req_payload.user_id];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SPOOL_ASSERT(a_holder_count, clock, reset, holder_ff == SW'($countones(busy_ff)), "holder count disagrees with busy slots")
   `SPOOL_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC, "accepted item did not enter execute")
   `SPOOL_ASSERT(a_hand_after_exec, clock, reset, (state_ff == S_HAND) |-> ($past(state_ff) == S_EXEC), "handoff write without execute")
   `SPOOL_ASSERT(a_queue_bound, clock, reset, q_count <= QCNT_W'(MAX_USERS), "wait queue overflow")

endmodule

// ===== hdl/spool_queue.sv =====
module spool_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  spool_pkg::qcmd_type          cmd,
   output logic [spool_pkg::UID_W-1:0]  head,
   output logic [spool_pkg::QCNT_W-1:0] count
);
   import spool_pkg::*;

   logic [UID_W-1:0]     cell_ff [MAX_USERS];
   logic [UID_W-1:0]     cell_in [MAX_USERS];
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;
   logic [MAX_USERS-1:0] hit;
   logic [UID_W-1:0]     pos;

   // Each live cell compares against the id; the single match gives the gap to close.
   always_comb begin
      hit = '0;
      pos = '0;
      for (int i = 0; i < MAX_USERS; i++) begin
         hit[i] = (QCNT_W'(i) < count_ff) && (cell_ff[i] == cmd.id);
         if (hit[i]) begin
            pos = pos | UID_W'(i);
         end
      end
      if (cmd.op == Q_POP) begin
         pos = '0;
      end

      cell_in  = cell_ff;
      count_in = count_ff;
      unique case (cmd.op)
         Q_NONE: begin
         end
         Q_PUSH: begin
            if (count_ff < QCNT_W'(MAX_USERS)) begin
               for (int i = 0; i < MAX_USERS; i++) begin
                  if (QCNT_W'(i) == count_ff) begin
                     cell_in[i] = cmd.id;
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         Q_DROP, Q_POP: begin
            if ((cmd.op == Q_POP && count_ff != '0) || (cmd.op == Q_DROP && |hit)) begin
               // close the gap: every cell at or behind it takes its successor
               for (int i = 0; i < MAX_USERS - 1; i++) begin
                  if (UID_W'(i) >= pos) begin
                     cell_in[i] = cell_ff[i + 1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign head  = cell_ff[0];
   assign count = count_ff;

endmodule

// ===== verif/tb_slot_pool_with_wait_queue.sv =====
module tb_slot_pool_with_wait_queue;
   import spool_pkg::*;

   localparam int POOL_SLOTS = 16;
   // Query and the spare opcode have no name in the package.
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int MISMATCH_PRINT_LIMIT = 100;
   localparam int ITEMS_PER_SETTING = 170;

   typedef logic [UID_W-1:0] uid_list_type [$];

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   req_type                     req_payload    = '0;
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   rsp_type                     rsp_payload;
   logic                        csr_write_en   = 1'b0;
   logic [CAP_W-1:0]            csr_write_data = '0;

   slot_pool_with_wait_queue #(
      .NUM_SLOTS(POOL_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Mirror of the pool: per-user mode and slot, busy flags, holder count,
   // wait line (head at index 0) and the capacity register.
   // ------------------------------------------------------------------
   ust_type               user_mode [MAX_USERS] = '{default: ST_IDLE};
   logic [SLOT_OUT_W-1:0] user_slot [MAX_USERS] = '{default: '0};
   bit                    slot_taken [1:POOL_SLOTS] = '{default: 1'b0};
   int                    holder_total = 0;
   logic [UID_W-1:0]      wait_line [$];
   logic [CAP_W-1:0]      capacity_setting = 5'd16;

   // Results still owed by the block, oldest first.
   rsp_type               pending_rsp [$];

   int  items_sent       = 0;
   int  results_checked  = 0;
   int  fail_count       = 0;
   int  mismatch_lines   = 0;
   int  settings_written = 0;
   int  peak_wait        = 0;
   int  peak_held        = 0;
   int  handoff_total    = 0;

   // Sender and receiver idling controls, flipped by the tests.
   bit  sender_idle   = 1'b1;
   bit  receiver_idle = 1'b1;
   int  hold_request  = 0;
   int  hold_left     = 0;
   int  stall_run     = 0;

   // Lowest numbered free slot, 0 when every slot is busy.
   function automatic logic [SLOT_OUT_W-1:0] lowest_open_slot();
      for (int s = 1; s <= POOL_SLOTS; s++) begin
         if (!slot_taken[s]) return SLOT_OUT_W'(s);
      end
      return '0;
   endfunction

   // Advance the mirror by one request and return the result it owes.
   function automatic rsp_type apply_request(req_type item);
      rsp_type               r;
      int                    eff_cap;
      logic [SLOT_OUT_W-1:0] s;
      logic [UID_W-1:0]      uid;
      logic [UID_W-1:0]      head;
      uid       = item.user_id;
      r         = '0;
      r.outcome = OC_STATUS;
      // Clamp capacities above the slot count; zero keeps the pool full.
      eff_cap   = (capacity_setting > POOL_SLOTS) ? POOL_SLOTS : capacity_setting;
      case (item.opcode)
         OP_ENTER: begin
            if (user_mode[uid] != ST_IDLE) begin
               r.outcome = OC_REJECTED;
            end else begin
               s = (holder_total < eff_cap) ? lowest_open_slot() : '0;
               if (s != 0) begin
                  slot_taken[s]  = 1'b1;
                  holder_total++;
                  user_mode[uid] = ST_HOLD;
                  user_slot[uid] = s;
                  r.outcome      = OC_GRANTED;
               end else if (wait_line.size() < MAX_USERS) begin
                  wait_line.push_back(uid);
                  user_mode[uid] = ST_WAIT;
                  r.outcome      = OC_QUEUED;
               end
            end
         end
         OP_LEAVE: begin
            if (user_mode[uid] == ST_IDLE) begin
               r.outcome = OC_IGNORED;
            end else if (user_mode[uid] == ST_WAIT) begin
               // Drop the waiter, keep the order of the others.
               for (int i = 0; i < wait_line.size(); i++) begin
                  if (wait_line[i] == uid) begin
                     wait_line.delete(i);
                     break;
                  end
               end
               user_mode[uid] = ST_IDLE;
               r.outcome      = OC_LEFT;
            end else begin
               if (wait_line.size() > 0) begin
                  // Hand the slot straight to the queue head; count is unchanged.
                  head            = wait_line.pop_front();
                  user_mode[head] = ST_HOLD;
                  user_slot[head] = user_slot[uid];
                  r.handoff_valid = 1'b1;
                  r.handoff_user  = head;
                  r.handoff_slot  = user_slot[uid];
                  handoff_total++;
               end else begin
                  slot_taken[user_slot[uid]] = 1'b0;
                  holder_total--;
               end
               user_mode[uid] = ST_IDLE;
               user_slot[uid] = '0;
               r.outcome      = OC_LEFT;
            end
         end
         default: ;  // query and the spare opcode only report
      endcase
      r.slot       = (user_mode[uid] == ST_HOLD) ? user_slot[uid] : '0;
      r.user_state = user_mode[uid];
      r.occupied   = CAP_W'(holder_total);
      r.waiting    = QCNT_W'(wait_line.size());
      if (holder_total > peak_held) peak_held = holder_total;
      if (wait_line.size() > peak_wait) peak_wait = wait_line.size();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic req_type make_item(logic [1:0] op, logic [UID_W-1:0] uid);
      req_type item;
      item.opcode  = op;
      item.user_id = uid;
      return item;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic uid_list_type users_with_mode(ust_type m);
      uid_list_type found;
      for (int u = 0; u < MAX_USERS; u++) begin
         if (user_mode[u] == m) found.push_back(UID_W'(u));
      end
      return found;
   endfunction

   function automatic uid_list_type shuffled_users();
      uid_list_type order;
      logic [UID_W-1:0] swap;
      int j;
      for (int u = 0; u < MAX_USERS; u++) order.push_back(UID_W'(u));
      for (int i = MAX_USERS - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      return order;
   endfunction

   // Bias leaves toward users that actually hold or wait, so that handoffs
   // and mid-queue removals happen often.
   function automatic req_type random_item();
      int               pick;
      logic [1:0]       op;
      logic [UID_W-1:0] uid;
      uid_list_type     pool;
      pick = $urandom_range(99);
      uid  = UID_W'($urandom_range(MAX_USERS - 1));
      if (pick < 42) begin
         op = OP_ENTER;
      end else if (pick < 80) begin
         op = OP_LEAVE;
         if (pick < 62) pool = users_with_mode(ST_HOLD);
         else if (pick < 74) pool = users_with_mode(ST_WAIT);
         if (pool.size() > 0) uid = pool[$urandom_range(pool.size() - 1)];
      end else if (pick < 93) begin
         op = OP_QUERY;
      end else begin
         op = OP_SPARE;
      end
      return make_item(op, uid);
   endfunction

   // Offer one item, hold it until accepted, then log what it must produce.
   // Valid stays high on return so a following item goes out back to back.
   task automatic send_item(req_type item);
      int gap;
      gap = sender_idle ? idle_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_request(item));
      items_sent++;
   endtask

   // Drop valid and wait until every owed result has come back, then let
   // the last status write-back settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain_results();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en     <= 1'b0;
      capacity_setting  = value;
      settings_written++;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall runs, plus a long hold counted here on request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_run > 0) begin
         stall_run--;
      end else if (receiver_idle && $urandom_range(2) == 0) begin
         rsp_stall <= 1'b1;
         stall_run  = idle_gap();
      end else begin
         rsp_stall <= 1'b0;
         stall_run  = $urandom_range(0, 8);
      end
   end

   // ------------------------------------------------------------------
   // Result checking: compare every accepted result with the oldest one owed.
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         if (mismatch_lines < MISMATCH_PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_lines++;
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (mismatch_lines < MISMATCH_PRINT_LIMIT) begin
               $display("%0t: result with nothing owed, expected none, actual %p",
                        $time, rsp_payload);
               mismatch_lines++;
            end
         end else begin
            want = pending_rsp.pop_front();
            check_field("outcome", 8'(want.outcome), 8'(rsp_payload.outcome));
            check_field("slot", 8'(want.slot), 8'(rsp_payload.slot));
            check_field("user_state", 8'(want.user_state), 8'(rsp_payload.user_state));
            check_field("handoff_valid", 8'(want.handoff_valid),
                        8'(rsp_payload.handoff_valid));
            check_field("handoff_user", 8'(want.handoff_user), 8'(rsp_payload.handoff_user));
            check_field("handoff_slot", 8'(want.handoff_slot), 8'(rsp_payload.handoff_slot));
            check_field("occupied", 8'(want.occupied), 8'(rsp_payload.occupied));
            check_field("waiting", 8'(want.waiting), 8'(rsp_payload.waiting));
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset capacity: query and spare opcode on idle users, leave while idle,
   // grants, double enter, free and reuse of the lowest slot.
   task automatic test_basic_ops();
      send_item(make_item(OP_QUERY, 6'd0));
      send_item(make_item(OP_SPARE, 6'd63));
      send_item(make_item(OP_LEAVE, 6'd5));
      send_item(make_item(OP_ENTER, 6'd0));
      send_item(make_item(OP_ENTER, 6'd63));
      send_item(make_item(OP_ENTER, 6'd0));
      send_item(make_item(OP_LEAVE, 6'd0));
      send_item(make_item(OP_ENTER, 6'd7));
   endtask

   // Capacity below the holders, zero capacity, capacity above the slot count;
   // removal of the waiter at the queue head and handoff to the queue head.
   task automatic test_capacity_edges();
      write_capacity(5'd1);
      send_item(make_item(OP_ENTER, 6'd10));
      send_item(make_item(OP_ENTER, 6'd11));
      send_item(make_item(OP_ENTER, 6'd10));
      send_item(make_item(OP_LEAVE, 6'd10));
      send_item(make_item(OP_LEAVE, 6'd63));
      write_capacity(5'd0);
      send_item(make_item(OP_ENTER, 6'd20));
      write_capacity(5'd31);
      send_item(make_item(OP_ENTER, 6'd21));
      send_item(make_item(OP_LEAVE, 6'd7));
   endtask

   // Empty the pool, fill the queue to all 64 users with capacity zero, then
   // at full capacity cycle each waiter out and back in so every slot fills
   // and the rest requeue behind them.
   task automatic test_queue_extremes();
      uid_list_type order;
      uid_list_type busy;
      write_capacity(5'd0);
      while (holder_total > 0 || wait_line.size() > 0) begin
         busy = users_with_mode(ST_HOLD);
         if (busy.size() == 0) busy = users_with_mode(ST_WAIT);
         send_item(make_item(OP_LEAVE, busy[$urandom_range(busy.size() - 1)]));
      end
      order = shuffled_users();
      foreach (order[i]) send_item(make_item(OP_ENTER, order[i]));
      send_item(make_item(OP_ENTER, UID_W'($urandom_range(MAX_USERS - 1))));
      send_item(make_item(OP_QUERY, order[0]));
      write_capacity(5'd16);
      order = shuffled_users();
      foreach (order[i]) begin
         send_item(make_item(OP_LEAVE, order[i]));
         send_item(make_item(OP_ENTER, order[i]));
      end
   endtask

   // Random traffic across several capacity settings; one stretch runs with
   // no idling on either side.
   task automatic test_random_traffic();
      logic [CAP_W-1:0] settings [8];
      settings = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16};
      settings[7] = CAP_W'($urandom_range(1, 16));
      foreach (settings[k]) begin
         write_capacity(settings[k]);
         sender_idle   = (k != 2);
         receiver_idle = (k != 2);
         repeat (ITEMS_PER_SETTING) send_item(random_item());
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // Hold the receiver off for a long stretch while items keep coming so the
   // block fills and stalls its input; then pause until everything is back.
   task automatic test_backpressure();
      drain_results();
      hold_request = 80;
      sender_idle  = 1'b0;
      repeat (40) send_item(random_item());
      sender_idle  = 1'b1;
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_capacity_edges();
      test_queue_extremes();
      test_random_traffic();
      test_backpressure();

      drain_results();
      repeat (10) @(posedge clock);

      $display("Covered %0d items and %0d results over %0d capacity writes, zero to 31.",
               items_sent, results_checked, settings_written);
      $display("Peak occupancy %0d, peak queue depth %0d, slot handoffs %0d.",
               peak_held, peak_wait, handoff_total);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timeout with %0d results still owed.", pending_rsp.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== slot_pool_with_wait_queue.f =====
+incdir+hdl
hdl/spool_pkg.sv
hdl/spool_queue.sv
hdl/slot_pool_with_wait_queue.sv
verif/tb_slot_pool_with_wait_queue.sv
